// ===== rtl/cdq_pkg.sv =====
// cdq_pkg: shared types and codes for the circular deque core.
// Used by cdq_ctrl, cdq_dpath and circular_deque_core; depends on nothing.
`default_nettype none

package cdq_pkg;

  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 4;
  localparam int IN_W     = 40;  // func + value, padded to whole bytes
  localparam int OUT_W    = 40;  // status + popped + occupancy, padded

  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted beat
    logic exec;  // run the captured operation
  } cdq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// cdq_ctrl: handshake sequencer of the circular deque core.
// Steps each beat through capture, execute and result hold; uses cdq_pkg.
`default_nettype none

module cdq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cdq_pkg::cdq_cmd_t      cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign cmd_o.load  = in_valid_i && (state_q == StIdle);
  assign cmd_o.exec  = (state_q == StExec);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        state_d = StOut;
      end
      StOut: begin
        // hold the result until the sink takes it
        if (out_ready_i) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cdq_dpath.sv =====
// cdq_dpath: slot memory, head/tail pointers, fill count and result registers.
// Driven by cdq_ctrl commands; uses cdq_pkg.
`default_nettype none

module cdq_dpath #(
  parameter int DEPTH = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire cdq_pkg::cdq_cmd_t                   cmd_i,
  input  wire logic [cdq_pkg::FUNC_W-1:0]          func_i,
  input  wire logic signed [cdq_pkg::WORD_W-1:0]   value_i,
  output logic [cdq_pkg::STATUS_W-1:0]             status_o,
  output logic signed [cdq_pkg::WORD_W-1:0]        popped_o,
  output logic [cdq_pkg::OCC_W-1:0]                occupancy_o
);

  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int WordW = cdq_pkg::WORD_W;
  localparam int OccW  = cdq_pkg::OCC_W;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [cdq_pkg::FUNC_W-1:0] func_q;
  logic [WordW-1:0]           value_q;
  logic [WordW-1:0]           mem_q [DEPTH];
  logic [WordW-1:0]           rdata_q;
  logic [PtrW-1:0]            head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [cdq_pkg::STATUS_W-1:0] status_q, status_d;
  logic                       popped_ok_q, popped_ok_d;
  logic [OccW-1:0]            occ_q;

  logic            is_push, is_empty, is_full;
  logic            wr_en;
  logic [PtrW-1:0] wr_addr, rd_addr;
  logic [PtrW-1:0] head_prev, head_next, tail_prev, tail_next;

  assign is_push  = (func_q == cdq_pkg::FUNC_PUSH_FRONT) ||
                    (func_q == cdq_pkg::FUNC_PUSH_REAR);
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntFull);

  assign head_prev = (head_q == '0) ? PtrLast : head_q - 1'b1;
  assign head_next = (head_q == PtrLast) ? '0 : head_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? PtrLast : tail_q - 1'b1;
  assign tail_next = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;

  assign rd_addr = (func_q == cdq_pkg::FUNC_POP_FRONT) ? head_q : tail_q;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    status_d    = cdq_pkg::STATUS_DONE;
    popped_ok_d = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    if (is_push) begin
      if (is_full) begin
        status_d = cdq_pkg::STATUS_OVERFLOW;
      end else begin
        wr_en   = 1'b1;
        count_d = count_q + 1'b1;
        if (is_empty) begin
          // restart both pointers at slot zero
          head_d  = '0;
          tail_d  = '0;
          wr_addr = '0;
        end else if (func_q == cdq_pkg::FUNC_PUSH_FRONT) begin
          head_d  = head_prev;
          wr_addr = head_prev;
        end else begin
          tail_d  = tail_next;
          wr_addr = tail_next;
        end
      end
    end else begin
      if (is_empty) begin
        status_d = cdq_pkg::STATUS_UNDERFLOW;
      end else begin
        popped_ok_d = 1'b1;
        count_d     = count_q - 1'b1;
        // last word out leaves the pointers where they are
        if (head_q != tail_q) begin
          if (func_q == cdq_pkg::FUNC_POP_FRONT) begin
            head_d = head_next;
          end else begin
            tail_d = tail_prev;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[wr_addr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rdata_q <= mem_q[rd_addr];
      occ_q   <= OccW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      status_q    <= cdq_pkg::STATUS_DONE;
      popped_ok_q <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      status_q    <= status_d;
      popped_ok_q <= popped_ok_d;
    end
  end

  assign status_o    = status_q;
  assign popped_o    = popped_ok_q ? rdata_q : '0;
  assign occupancy_o = occ_q;

endmodule

`default_nettype wire

// ===== rtl/circular_deque_core.sv =====
// circular_deque_core: double-ended queue of 32-bit words in a circular buffer.
// Instantiates cdq_ctrl and cdq_dpath; uses cdq_pkg.
//
//   channel  | direction | beat contents (lowest bits first)
//   s_axis   | in        | tdata: func[1:0], value[33:2], zero pad[39:34]
//   m_axis   | out       | tdata: status[1:0], popped[33:2], occupancy[37:34], pad
//
// Each beat steps through capture, execute (one slot write or one
// registered slot read plus pointer update), then the result is held.
// One beat is in flight at a time; s_axis_tready is low until the result
// beat leaves, and a stalled m_axis holds its result unchanged.
// Reset empties the deque; slot contents are not cleared, and a popped word
// is only returned from a slot that was written.
`default_nettype none

module circular_deque_core #(
  parameter int DEPTH = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [cdq_pkg::IN_W-1:0]     s_axis_tdata,   // func, value
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [cdq_pkg::OUT_W-1:0]         m_axis_tdata    // status, popped, occupancy
);

  cdq_pkg::cdq_cmd_t                   cmd;
  logic [cdq_pkg::STATUS_W-1:0]        status;
  logic signed [cdq_pkg::WORD_W-1:0]   popped;
  logic [cdq_pkg::OCC_W-1:0]           occupancy;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (s_axis_tdata[1:0]),
    .value_i     (s_axis_tdata[33:2]),
    .status_o    (status),
    .popped_o    (popped),
    .occupancy_o (occupancy)
  );

  assign m_axis_tdata = {2'b00, occupancy, popped, status};

  // No new beat is taken while a result is pending.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  // A taken beat passes through the execute state, then its result is presented.
  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
    else $error("result not presented after execute");

  // Failed operations return no word.
  a_fail_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == cdq_pkg::STATUS_UNDERFLOW ||
                       status == cdq_pkg::STATUS_OVERFLOW)) |-> (popped == '0))
    else $error("word returned by a failed operation");

endmodule

`default_nettype wire
